// ----- sv/encoder_rotation_tap_generator_core_assert.svh -----
// Assertion macros for the encoder rotation tap generator.
// Simulation builds get concurrent assertions clocked on aclk; synthesis builds get nothing.
`ifndef ENCODER_ROTATION_TAP_GENERATOR_CORE_ASSERT_SVH
`define ENCODER_ROTATION_TAP_GENERATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only while the block is out of reset.
`define ERTG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define ERTG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define ERTG_ASSERT(lbl, prop, msg)
`define ERTG_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- sv/ertg_pkg.sv -----
// ----------------------------------------------------------------------------
// ertg_pkg: shared definitions for the encoder rotation tap generator
// Widths, constants, register map, queue entry and divider port types.
// ----------------------------------------------------------------------------
`default_nettype none

package ertg_pkg;

    // Sizing.
    localparam int LAYERS        = 8;
    localparam int MAX_TAPS      = 32;
    localparam int MICRO_PER_DEG = 1000000;
    localparam int FULL_TURN     = 360;

    // Field widths.
    localparam int LAYER_W = 3;
    localparam int WHOLE_W = 10;
    localparam int MICRO_W = 21;
    localparam int STEPS_W = 9;
    localparam int ID_W    = 16;
    localparam int PARAM_W = 32;
    localparam int HOLD_W  = 16;

    // Internal widths.
    localparam int LAYER_IDX_W = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int RW_W        = WHOLE_W + 1;
    localparam int RM_W        = MICRO_W + 1;
    localparam int MAG_W       = $clog2(MAX_TAPS + 1);
    localparam int RUN_W       = $clog2(2 * MAX_TAPS + 1);
    localparam int DVD_W       = 10;
    localparam int DVS_W       = STEPS_W;
    localparam int DIV_CNT_W   = $clog2(DVD_W + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register port.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Carry thresholds for the micro-degree accumulator.
    localparam logic signed [RM_W-1:0] MICRO_1 = RM_W'(MICRO_PER_DEG);
    localparam logic signed [RM_W-1:0] MICRO_2 = RM_W'(2 * MICRO_PER_DEG);

    // Register map.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_TAP_HOLD,
        REG_STEPS,
        REG_CW_ID,
        REG_CW_P1,
        REG_CW_P2,
        REG_CCW_ID,
        REG_CCW_P1,
        REG_CCW_P2
    } reg_idx_t;

    typedef struct packed {
        logic [HOLD_W-1:0]  tap_hold_ms;
        logic [STEPS_W-1:0] steps_per_rotation;
        logic [ID_W-1:0]    cw_behavior_id;
        logic [PARAM_W-1:0] cw_first_param;
        logic [PARAM_W-1:0] cw_second_param;
        logic [ID_W-1:0]    ccw_behavior_id;
        logic [PARAM_W-1:0] ccw_first_param;
        logic [PARAM_W-1:0] ccw_second_param;
    } cfg_t;

    // One tap run handed from the front to the back.
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_ACC,
        F_DPT_START,
        F_DPT_WAIT,
        F_QUO_START,
        F_QUO_WAIT,
        F_PUSH
    } front_state_t;

    // Clamp a trigger magnitude to the tap limit.
    function automatic logic [MAG_W-1:0] sat_mag(input logic [RM_W-1:0] v);
        if (v > RM_W'(MAX_TAPS)) begin
            return MAG_W'(MAX_TAPS);
        end
        return MAG_W'(v);
    endfunction

endpackage

`default_nettype wire

// ----- sv/ertg_div.sv -----
// ----------------------------------------------------------------------------
// ertg_div: serial unsigned divider
// Restoring division, one quotient bit per cycle, shared by the front end.
// ----------------------------------------------------------------------------
`default_nettype none

module ertg_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  ertg_pkg::div_req_t req,
    output ertg_pkg::div_rsp_t rsp
);
    import ertg_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0]     quo_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [DVS_W-1:0]     dvs_reg;
    logic [DVS_W:0]       trial;
    logic                 fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    // Control: busy while the quotient bits are formed, done pulses as busy drops.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend register fills with quotient bits from the right.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= DVS_W'(trial - {1'b0, dvs_reg});
            end else begin
                rem_reg <= trial[DVS_W-1:0];
            end
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

// ----- sv/ertg_front.sv -----
// ----------------------------------------------------------------------------
// ertg_front: report intake and trigger counting
// Accepts encoder reports, updates the per-layer remainder and queues tap runs.
// ----------------------------------------------------------------------------
`default_nettype none

module ertg_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ertg_pkg::LAYER_W-1:0]        s_layer,
    input  logic signed [ertg_pkg::WHOLE_W-1:0] s_whole_degrees,
    input  logic signed [ertg_pkg::MICRO_W-1:0] s_micro_degrees,
    input  logic                                s_fire,
    input  logic [ertg_pkg::STEPS_W-1:0]        steps_per_rotation,
    output ertg_pkg::div_req_t                  div_req,
    input  ertg_pkg::div_rsp_t                  div_rsp,
    output logic                                job_push,
    output ertg_pkg::job_t                      job,
    input  ertg_pkg::q_stat_t                   q_stat
);
    import ertg_pkg::*;

    front_state_t state_reg, state_next;

    logic [LAYER_W-1:0]        layer_reg;
    logic signed [WHOLE_W-1:0] whole_reg;
    logic signed [MICRO_W-1:0] micro_reg;
    logic                      fire_reg;
    logic signed [MICRO_W-1:0] rm_reg;
    logic [DVD_W-1:0]          abs_rw_reg;
    logic                      neg_reg;
    logic [DVS_W-1:0]          dpt_reg;
    job_t                      job_reg;
    logic                      need_reg;

    logic signed [WHOLE_W-1:0] whole_rem_reg [LAYERS];
    logic signed [MICRO_W-1:0] micro_rem_reg [LAYERS];

    logic                      accept;
    logic                      lay_ok;
    logic [LAYER_IDX_W-1:0]    lay_idx;
    logic signed [WHOLE_W-1:0] rem_w;
    logic signed [MICRO_W-1:0] rem_m;
    logic signed [RW_W-1:0]    rw0;
    logic signed [RW_W-1:0]    rw1;
    logic signed [RM_W-1:0]    rm0;
    logic signed [RM_W-1:0]    rm_adj;
    logic signed [2:0]         carry;
    logic signed [RM_W-1:0]    micro_ext;
    logic [RM_W-1:0]           micro_abs;
    logic signed [WHOLE_W-1:0] rem_pos;
    logic signed [WHOLE_W-1:0] rem_new;

    assign accept  = s_valid && s_ready;
    assign lay_ok  = 32'(layer_reg) < 32'(LAYERS);
    assign lay_idx = LAYER_IDX_W'(layer_reg);

    // Add the report to the stored remainder and carry micro-degrees into whole degrees.
    always_comb begin
        rem_w = lay_ok ? whole_rem_reg[lay_idx] : '0;
        rem_m = lay_ok ? micro_rem_reg[lay_idx] : '0;
        rw0   = RW_W'(rem_w) + RW_W'(whole_reg);
        rm0   = RM_W'(rem_m) + RM_W'(micro_reg);
        if (rm0 >= MICRO_2) begin
            carry  = 3'sd2;
            rm_adj = rm0 - MICRO_2;
        end else if (rm0 >= MICRO_1) begin
            carry  = 3'sd1;
            rm_adj = rm0 - MICRO_1;
        end else if (rm0 <= -MICRO_2) begin
            carry  = -3'sd2;
            rm_adj = rm0 + MICRO_2;
        end else if (rm0 <= -MICRO_1) begin
            carry  = -3'sd1;
            rm_adj = rm0 + MICRO_1;
        end else begin
            carry  = 3'sd0;
            rm_adj = rm0;
        end
        rw1 = rw0 + RW_W'(carry);
    end

    // Magnitude of a direct trigger count.
    assign micro_ext = RM_W'(s_micro_degrees);
    assign micro_abs = (micro_ext < 0) ? RM_W'(-micro_ext) : RM_W'(micro_ext);

    // The whole-degree remainder takes the sign of the dividend.
    assign rem_pos = WHOLE_W'(div_rsp.remainder);
    assign rem_new = neg_reg ? -rem_pos : rem_pos;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state, divider requests and queue push.
    always_comb begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.dividend = abs_rw_reg;
        div_req.divisor  = dpt_reg;
        job_push         = 1'b0;
        s_ready          = 1'b0;
        unique case (state_reg)
            F_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = (s_whole_degrees == '0) ? F_PUSH : F_ACC;
                end
            end
            F_ACC: begin
                state_next = F_DPT_START;
            end
            F_DPT_START: begin
                if (steps_per_rotation == '0) begin
                    state_next = F_QUO_START;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DVD_W'(FULL_TURN);
                    div_req.divisor  = steps_per_rotation;
                    state_next       = F_DPT_WAIT;
                end
            end
            F_DPT_WAIT: begin
                if (div_rsp.done) begin
                    state_next = F_QUO_START;
                end
            end
            F_QUO_START: begin
                div_req.start = 1'b1;
                state_next    = F_QUO_WAIT;
            end
            F_QUO_WAIT: begin
                if (div_rsp.done) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                job_push = need_reg && !q_stat.full;
                if (!need_reg || !q_stat.full) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Item datapath.
    always_ff @(posedge aclk) begin
        if (accept) begin
            layer_reg   <= s_layer;
            whole_reg   <= s_whole_degrees;
            micro_reg   <= s_micro_degrees;
            fire_reg    <= s_fire;
            job_reg.neg <= s_micro_degrees < 0;
            job_reg.mag <= sat_mag(micro_abs);
            need_reg    <= s_fire && (s_micro_degrees != '0);
        end
        if (state_reg == F_ACC) begin
            rm_reg     <= MICRO_W'(rm_adj);
            neg_reg    <= rw1 < 0;
            abs_rw_reg <= (rw1 < 0) ? DVD_W'(-rw1) : DVD_W'(rw1);
        end
        if (state_reg == F_DPT_START && steps_per_rotation == '0) begin
            dpt_reg <= DVS_W'(FULL_TURN);
        end
        if (state_reg == F_DPT_WAIT && div_rsp.done) begin
            dpt_reg <= (div_rsp.quotient == '0) ? DVS_W'(1) : DVS_W'(div_rsp.quotient);
        end
        if (state_reg == F_QUO_WAIT && div_rsp.done) begin
            job_reg.neg <= neg_reg;
            job_reg.mag <= sat_mag(RM_W'(div_rsp.quotient));
            need_reg    <= fire_reg && (div_rsp.quotient != '0);
        end
    end

    // Per-layer remainder store, cleared at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAYERS; i++) begin
                whole_rem_reg[i] <= '0;
                micro_rem_reg[i] <= '0;
            end
        end else if (state_reg == F_QUO_WAIT && div_rsp.done && lay_ok) begin
            whole_rem_reg[lay_idx] <= rem_new;
            micro_rem_reg[lay_idx] <= rm_reg;
        end
    end

    assign job = job_reg;

endmodule

`default_nettype wire

// ----- sv/ertg_queue.sv -----
// ----------------------------------------------------------------------------
// ertg_queue: tap run queue
// Small first-in first-out buffer of pending tap runs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ertg_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ertg_pkg::job_t    push_job,
    input  logic              pop,
    output ertg_pkg::job_t    head,
    output ertg_pkg::q_stat_t stat
);
    import ertg_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign stat.empty = cnt_reg == '0;

endmodule

`default_nettype wire

// ----- sv/ertg_back.sv -----
// ----------------------------------------------------------------------------
// ertg_back: tap emitter
// Turns each queued tap run into alternating press and release items.
// ----------------------------------------------------------------------------
`default_nettype none

module ertg_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ertg_pkg::cfg_t               cfg,
    input  ertg_pkg::job_t               job,
    input  ertg_pkg::q_stat_t            q_stat,
    output logic                         job_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ertg_pkg::ID_W-1:0]    m_behavior_id,
    output logic [ertg_pkg::PARAM_W-1:0] m_first_param,
    output logic [ertg_pkg::PARAM_W-1:0] m_second_param,
    output logic                         m_pressed,
    output logic [ertg_pkg::HOLD_W-1:0]  m_hold_ms,
    output logic                         m_last
);
    import ertg_pkg::*;

    logic               active_reg;
    logic               neg_reg;
    logic [RUN_W-1:0]   total_reg;
    logic [RUN_W-1:0]   idx_reg;
    logic               m_valid_reg;
    logic [ID_W-1:0]    bid_reg;
    logic [PARAM_W-1:0] p1_reg;
    logic [PARAM_W-1:0] p2_reg;
    logic               pressed_reg;
    logic [HOLD_W-1:0]  hold_reg;
    logic               last_reg;

    logic               out_free;
    logic               emit;
    logic               final_item;

    assign out_free   = !m_valid_reg || m_ready;
    assign emit       = active_reg && out_free;
    assign final_item = (idx_reg + 1'b1) == total_reg;
    assign job_pop    = !active_reg && !q_stat.empty;

    // Run control and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (job_pop) begin
                active_reg <= 1'b1;
            end else if (emit && final_item) begin
                active_reg <= 1'b0;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Run counters and output item register.
    always_ff @(posedge aclk) begin
        if (job_pop) begin
            neg_reg   <= job.neg;
            total_reg <= RUN_W'(job.mag) << 1;
            idx_reg   <= '0;
        end
        if (emit) begin
            idx_reg     <= idx_reg + 1'b1;
            bid_reg     <= neg_reg ? cfg.ccw_behavior_id : cfg.cw_behavior_id;
            p1_reg      <= neg_reg ? cfg.ccw_first_param : cfg.cw_first_param;
            p2_reg      <= neg_reg ? cfg.ccw_second_param : cfg.cw_second_param;
            pressed_reg <= !idx_reg[0];
            hold_reg    <= idx_reg[0] ? '0 : cfg.tap_hold_ms;
            last_reg    <= final_item;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_behavior_id  = bid_reg;
    assign m_first_param  = p1_reg;
    assign m_second_param = p2_reg;
    assign m_pressed      = pressed_reg;
    assign m_hold_ms      = hold_reg;
    assign m_last         = last_reg;

endmodule

`default_nettype wire

// ----- sv/encoder_rotation_tap_generator_core.sv -----
// ----------------------------------------------------------------------------
// encoder_rotation_tap_generator_core: encoder rotation to tap events
// Accumulates encoder reports per layer and emits press/release tap items.
// ----------------------------------------------------------------------------
// An encoder report with nonzero whole degrees is accepted, added to its layer's
// remainder and then passes twice through one shared serial divider: first for
// the degrees per trigger and then for the trigger count. When steps per
// rotation is zero the first pass is skipped. A report in direct count mode
// (zero whole degrees) goes from intake straight to the push state. The back end
// then emits one item per cycle while m_ready stays high, two per tap and at most
// 64 per report, and a four-entry run queue lets the front end take the next
// report meanwhile. The remainder store is cleared by reset itself, with no
// clearing pass.
`default_nettype none
`include "encoder_rotation_tap_generator_core_assert.svh"

module encoder_rotation_tap_generator_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ertg_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ertg_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ertg_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // Report input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ertg_pkg::LAYER_W-1:0]        s_layer,
    input  logic signed [ertg_pkg::WHOLE_W-1:0] s_whole_degrees,
    input  logic signed [ertg_pkg::MICRO_W-1:0] s_micro_degrees,
    input  logic                                s_fire,
    // Tap output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ertg_pkg::ID_W-1:0]           m_behavior_id,
    output logic [ertg_pkg::PARAM_W-1:0]        m_first_param,
    output logic [ertg_pkg::PARAM_W-1:0]        m_second_param,
    output logic                                m_pressed,
    output logic [ertg_pkg::HOLD_W-1:0]         m_hold_ms,
    output logic                                m_last
);
    import ertg_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     wr_en;

    div_req_t div_req;
    div_rsp_t div_rsp;
    logic     job_push;
    logic     job_pop;
    job_t     push_job;
    job_t     head_job;
    q_stat_t  q_stat;

    // Register access.
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tap_hold_ms        <= HOLD_W'(5);
            cfg_reg.steps_per_rotation <= STEPS_W'(20);
            cfg_reg.cw_behavior_id     <= '0;
            cfg_reg.cw_first_param     <= '0;
            cfg_reg.cw_second_param    <= '0;
            cfg_reg.ccw_behavior_id    <= '0;
            cfg_reg.ccw_first_param    <= '0;
            cfg_reg.ccw_second_param   <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TAP_HOLD: cfg_reg.tap_hold_ms        <= pwdata[HOLD_W-1:0];
                REG_STEPS:    cfg_reg.steps_per_rotation <= pwdata[STEPS_W-1:0];
                REG_CW_ID:    cfg_reg.cw_behavior_id     <= pwdata[ID_W-1:0];
                REG_CW_P1:    cfg_reg.cw_first_param     <= pwdata[PARAM_W-1:0];
                REG_CW_P2:    cfg_reg.cw_second_param    <= pwdata[PARAM_W-1:0];
                REG_CCW_ID:   cfg_reg.ccw_behavior_id    <= pwdata[ID_W-1:0];
                REG_CCW_P1:   cfg_reg.ccw_first_param    <= pwdata[PARAM_W-1:0];
                REG_CCW_P2:   cfg_reg.ccw_second_param   <= pwdata[PARAM_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read mux.
    always_comb begin
        unique case (reg_idx)
            REG_TAP_HOLD: prdata = APB_DATA_W'(cfg_reg.tap_hold_ms);
            REG_STEPS:    prdata = APB_DATA_W'(cfg_reg.steps_per_rotation);
            REG_CW_ID:    prdata = APB_DATA_W'(cfg_reg.cw_behavior_id);
            REG_CW_P1:    prdata = APB_DATA_W'(cfg_reg.cw_first_param);
            REG_CW_P2:    prdata = APB_DATA_W'(cfg_reg.cw_second_param);
            REG_CCW_ID:   prdata = APB_DATA_W'(cfg_reg.ccw_behavior_id);
            REG_CCW_P1:   prdata = APB_DATA_W'(cfg_reg.ccw_first_param);
            REG_CCW_P2:   prdata = APB_DATA_W'(cfg_reg.ccw_second_param);
            default:      prdata = '0;
        endcase
    end

    // Front end: intake, remainder update and trigger count.
    ertg_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_layer            (s_layer),
        .s_whole_degrees    (s_whole_degrees),
        .s_micro_degrees    (s_micro_degrees),
        .s_fire             (s_fire),
        .steps_per_rotation (cfg_reg.steps_per_rotation),
        .div_req            (div_req),
        .div_rsp            (div_rsp),
        .job_push           (job_push),
        .job                (push_job),
        .q_stat             (q_stat)
    );

    // Shared serial divider.
    ertg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Run queue between the two halves.
    ertg_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .head     (head_job),
        .stat     (q_stat)
    );

    // Back end: tap emission.
    ertg_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .job            (head_job),
        .q_stat         (q_stat),
        .job_pop        (job_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_behavior_id  (m_behavior_id),
        .m_first_param  (m_first_param),
        .m_second_param (m_second_param),
        .m_pressed      (m_pressed),
        .m_hold_ms      (m_hold_ms),
        .m_last         (m_last)
    );

    // Design checks.
    `ERTG_ASSERT(a_no_push_when_full, job_push |-> !q_stat.full, "run pushed into a full queue")
    `ERTG_ASSERT(a_no_pop_when_empty, job_pop |-> !q_stat.empty, "run popped from an empty queue")
    `ERTG_ASSERT(a_last_is_release, m_valid && m_last |-> !m_pressed, "final item of a run is a press")
    `ERTG_ASSERT(a_release_no_hold, m_valid && !m_pressed |-> m_hold_ms == '0, "release carries a hold")
    `ERTG_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_valid && s_ready, "block not idle after reset")

endmodule

`default_nettype wire
